/* hw/rtl/spc_pkg.sv */
// shared constants and control/status types for the sieve prime counter
`timescale 1ns / 1ps
`default_nettype none
package spc_pkg;

    // sieve size and derived widths
    localparam int MAX_N   = 1024;
    localparam int ADDR_W  = $clog2(MAX_N);
    localparam int IDX_W   = ADDR_W + 1;
    localparam int FIELD_W = 11;
    localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;

    // first sieving base
    localparam int FIRST_BASE = 2;

    // commands from controller to datapath
    typedef struct packed {
        logic start;
        logic fill_step;
        logic base_step;
        logic check_step;
        logic cross_step;
        logic count_step;
        logic load_out;
    } spc_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic fill_done;
        logic sieve_done;
        logic flag_set;
        logic cross_done;
        logic count_done;
        logic out_free;
    } spc_status_t;

endpackage
`default_nettype wire

/* hw/rtl/spc_ram.sv */
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module spc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/spc_ctrl.sv */
// controller state machine for the sieve prime counter
`timescale 1ns / 1ps
`default_nettype none
module spc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire spc_pkg::spc_status_t status,
    output spc_pkg::spc_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_BASE  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_CROSS = 7'b0010000,
        S_COUNT = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.base_step = 1'b1;
                state_next    = status.sieve_done ? S_COUNT : S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check_step = 1'b1;
                state_next     = status.flag_set ? S_CROSS : S_BASE;
            end
            S_CROSS:
            begin
                cmd.cross_step = 1'b1;
                if (status.cross_done)
                begin
                    state_next = S_BASE;
                end
            end
            S_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (status.count_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/spc_dp.sv */
// datapath: flag store, sieve indexes, survivor counter and output register
`timescale 1ns / 1ps
`default_nettype none
module spc_dp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire spc_pkg::spc_cmd_t              cmd,
    output spc_pkg::spc_status_t                status,
    input  wire logic [spc_pkg::FIELD_W-1:0]    limit,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [spc_pkg::FIELD_W-1:0]    prime_count
);

    localparam logic [spc_pkg::IDX_W-1:0] MAX_N_I   = spc_pkg::IDX_W'(spc_pkg::MAX_N);
    localparam logic [spc_pkg::IDX_W-1:0] BASE0     = spc_pkg::IDX_W'(spc_pkg::FIRST_BASE);
    localparam logic [spc_pkg::IDX_W-1:0] SQ0       =
        spc_pkg::IDX_W'(spc_pkg::FIRST_BASE * spc_pkg::FIRST_BASE);

    logic [spc_pkg::IDX_W-1:0]   n_reg;
    logic [spc_pkg::IDX_W-1:0]   scan_reg;
    logic [spc_pkg::IDX_W-1:0]   base_reg;
    logic [spc_pkg::IDX_W-1:0]   sq_reg;
    logic [spc_pkg::IDX_W-1:0]   mult_reg;
    logic [spc_pkg::IDX_W-1:0]   cnt_reg;
    logic                        pend_reg;
    logic                        out_valid_reg;
    logic [spc_pkg::FIELD_W-1:0] out_data_reg;

    logic [spc_pkg::IDX_W-1:0]   limit_ext;
    logic [spc_pkg::IDX_W-1:0]   n_sat;
    logic [spc_pkg::IDX_W-1:0]   sq_adv;
    logic                        scan_lt_n;
    logic                        mult_lt_n;
    logic                        wr_en;
    logic [spc_pkg::ADDR_W-1:0]  wr_addr;
    logic                        wr_data;
    logic                        rd_en;
    logic [spc_pkg::ADDR_W-1:0]  rd_addr;
    logic                        rd_data;

    // limit saturation and compares
    always_comb
    begin
        limit_ext = spc_pkg::IDX_W'(limit);
        n_sat     = (limit_ext > MAX_N_I) ? MAX_N_I : limit_ext;
        sq_adv    = sq_reg + {base_reg[spc_pkg::IDX_W-2:0], 1'b1};
        scan_lt_n = scan_reg < n_reg;
        mult_lt_n = mult_reg < n_reg;
    end

    // flag store port control
    always_comb
    begin
        wr_en   = (cmd.fill_step && scan_lt_n) || (cmd.cross_step && mult_lt_n);
        wr_addr = cmd.fill_step ? scan_reg[spc_pkg::ADDR_W-1:0]
                                : mult_reg[spc_pkg::ADDR_W-1:0];
        wr_data = cmd.fill_step;
        rd_en   = (cmd.base_step && !status.sieve_done) || (cmd.count_step && scan_lt_n);
        rd_addr = cmd.base_step ? base_reg[spc_pkg::ADDR_W-1:0]
                                : scan_reg[spc_pkg::ADDR_W-1:0];
    end

    spc_ram #(
        .WIDTH (1),
        .DEPTH (spc_pkg::MAX_N)
    ) u_flags (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // status to controller
    always_comb
    begin
        status.fill_done  = !scan_lt_n;
        status.sieve_done = sq_reg >= n_reg;
        status.flag_set   = rd_data;
        status.cross_done = !mult_lt_n;
        status.count_done = !scan_lt_n && !pend_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // sieve indexes and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            scan_reg <= '0;
            base_reg <= '0;
            sq_reg   <= '0;
            mult_reg <= '0;
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                n_reg    <= n_sat;
                scan_reg <= '0;
                base_reg <= BASE0;
                sq_reg   <= SQ0;
                cnt_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.fill_step && scan_lt_n)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
            // sieving finished: rewind scan for the count pass
            if (cmd.base_step && status.sieve_done)
            begin
                scan_reg <= BASE0;
                pend_reg <= 1'b0;
            end
            // base still marked: first multiple is its square
            if (cmd.check_step)
            begin
                if (rd_data)
                begin
                    mult_reg <= sq_reg;
                end
                else
                begin
                    base_reg <= base_reg + 1'b1;
                    sq_reg   <= sq_adv;
                end
            end
            if (cmd.cross_step)
            begin
                if (mult_lt_n)
                begin
                    mult_reg <= mult_reg + base_reg;
                end
                else
                begin
                    base_reg <= base_reg + 1'b1;
                    sq_reg   <= sq_adv;
                end
            end
            // count pass: read ahead one flag, tally the previous read
            if (cmd.count_step)
            begin
                pend_reg <= scan_lt_n;
                if (scan_lt_n)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (pend_reg && rd_data)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= spc_pkg::FIELD_W'(cnt_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign prime_count = out_data_reg;

    // a result is never loaded over one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending result");

    // flag writes stay below the request's limit
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ({1'b0, wr_addr} < n_reg))
        else $error("flag write beyond limit");

    // survivor count cannot exceed the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= n_reg)
        else $error("survivor count exceeds limit");

    // a taken result without a reload leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !cmd.load_out) |=> !out_valid_reg)
        else $error("output valid held after handshake");

endmodule
`default_nettype wire

/* hw/rtl/sieve_prime_count.sv */
// Prime counter: top level joining the sieve controller and datapath.
//
// Usage:
//   The slave channel (s_tvalid/s_tready/s_tdata) takes one request, a limit
//   n in s_tdata[10:0]; limits above the 1024-entry sieve saturate to 1024.
//   The master channel (m_tvalid/m_tready/m_tdata) returns the number of
//   primes p with 2 <= p < n in m_tdata[10:0]; limits of 0, 1 or 2 give 0.
//   One request is worked at a time; s_tready is high only while idle.
// Pacing:
//   The single flag memory sets the pace: one fill write, crossing write
//   or count read per cycle.
// Reset:
//   rst_n clears the controller and output valid; no memory clearing pass
//   is needed because each request rewrites every flag it later reads.
// Stall:
//   The result sits in an output register; a new request is accepted while
//   it waits. A finished result is held back until the previous one is taken.
`timescale 1ns / 1ps
`default_nettype none
module sieve_prime_count (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [spc_pkg::TDATA_W-1:0]   s_tdata,  // [10:0] limit, upper bits zero
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [spc_pkg::TDATA_W-1:0]   m_tdata   // [10:0] prime_count, upper bits zero
);

    spc_pkg::spc_cmd_t           cmd;
    spc_pkg::spc_status_t        status;
    logic [spc_pkg::FIELD_W-1:0] prime_count;

    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .status    (status),
        .cmd       (cmd)
    );

    spc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .limit       (s_tdata[spc_pkg::FIELD_W-1:0]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .prime_count (prime_count)
    );

    // pad the result to whole bytes
    assign m_tdata = spc_pkg::TDATA_W'(prime_count);

endmodule
`default_nettype wire

/* dv/sieve_prime_count_checker.sv */
// checker for the sieve prime counter: predicts each count and compares results
`timescale 1ns / 1ps
module sieve_prime_count_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [spc_pkg::TDATA_W-1:0]   s_tdata,   // [10:0] limit
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [spc_pkg::TDATA_W-1:0]   m_tdata,   // [10:0] prime_count
    output int                            fail_count,
    output int                            pending_count,
    output int                            checked_count
);

    localparam int REPORT_LIMIT = 10;

    // counts still owed by the block, oldest request first
    logic [spc_pkg::FIELD_W-1:0] prime_counts_due[$];
    logic [spc_pkg::FIELD_W-1:0] wanted_count;
    int                          mismatches = 0;
    int                          checked = 0;

    // primes p with 2 <= p < limit, limit clipped to the sieve size
    function automatic logic [spc_pkg::FIELD_W-1:0] count_primes_below(
        input logic [spc_pkg::FIELD_W-1:0] limit
    );
        bit crossed [spc_pkg::MAX_N];
        int n;
        int base;
        int mult;
        int total;
        n = (int'(limit) > spc_pkg::MAX_N) ? spc_pkg::MAX_N : int'(limit);
        for (int k = 0; k < spc_pkg::MAX_N; k++)
            crossed[k] = 1'b0;
        for (base = spc_pkg::FIRST_BASE; base * base < n; base++)
            if (!crossed[base])
                for (mult = base * base; mult < n; mult += base)
                    crossed[mult] = 1'b1;
        total = 0;
        for (base = spc_pkg::FIRST_BASE; base < n; base++)
            if (!crossed[base])
                total++;
        return total[spc_pkg::FIELD_W-1:0];
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // results are checked before the same-edge request is queued
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (prime_counts_due.size() == 0)
                begin
                    note_mismatch("result with no request outstanding", -1,
                                  int'(m_tdata[spc_pkg::FIELD_W-1:0]));
                end
                else
                begin
                    wanted_count = prime_counts_due.pop_front();
                    checked++;
                    if (m_tdata[spc_pkg::FIELD_W-1:0] !== wanted_count)
                        note_mismatch("prime_count", int'(wanted_count),
                                      int'(m_tdata[spc_pkg::FIELD_W-1:0]));
                end
            end
            if (s_tvalid && s_tready)
                prime_counts_due.push_back(
                    count_primes_below(s_tdata[spc_pkg::FIELD_W-1:0]));
        end
        fail_count    <= mismatches;
        pending_count <= prime_counts_due.size();
        checked_count <= checked;
    end

endmodule

/* dv/sieve_prime_count_test.sv */
// testbench top for the sieve prime counter: stimulus, handshake idling and verdict
`timescale 1ns / 1ps
module sieve_prime_count_test;

    localparam int RANDOM_REQUESTS = 122;
    localparam int PHASE_LEN       = 30;
    localparam int DRAIN_CYCLES    = 20;
    localparam int LIMIT_CYCLES    = 3_000_000;

    logic                        clk      = 1'b0;
    logic                        rst_n    = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic [spc_pkg::TDATA_W-1:0] s_tdata  = '0;
    logic                        m_tready = 1'b0;
    logic                        s_tready;
    logic                        m_tvalid;
    logic [spc_pkg::TDATA_W-1:0] m_tdata;

    int fail_count;
    int pending_count;
    int checked_count;
    int cycle_count     = 0;
    int stall_left      = 0;
    bit gaps_on         = 1'b1;
    int sent_count      = 0;
    int saturated_count = 0;
    int tiny_count      = 0;

    // small limits, prime boundaries, sieve-size edges and saturating limits
    int unsigned directed_limits [18] = '{0, 1, 2, 3, 4, 5, 6, 11, 12, 97, 128, 511,
                                          512, 1023, 1024, 1025, 1536, 2047};

    always #5 clk = ~clk;

    sieve_prime_count dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sieve_prime_count_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // mostly small limits to keep the run short, a few full-size and saturating ones
    function automatic logic [spc_pkg::FIELD_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return spc_pkg::FIELD_W'($urandom_range(0, 40));
        if (r < 80)
            return spc_pkg::FIELD_W'($urandom_range(41, spc_pkg::MAX_N - 1));
        if (r < 92)
            return spc_pkg::FIELD_W'($urandom_range(spc_pkg::MAX_N - 24, spc_pkg::MAX_N));
        return spc_pkg::FIELD_W'($urandom_range(spc_pkg::MAX_N + 1,
                                                (1 << spc_pkg::FIELD_W) - 1));
    endfunction

    // one request, returns at the edge where it is accepted
    task automatic send_limit(input logic [spc_pkg::FIELD_W-1:0] limit);
        int gap;
        gap = gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(spc_pkg::TDATA_W - spc_pkg::FIELD_W){1'b0}}, limit};
        do @(posedge clk); while (!s_tready);
        sent_count++;
        if (int'(limit) >= spc_pkg::MAX_N)
            saturated_count++;
        if (limit < 3)
            tiny_count++;
    endtask

    // hold off new requests until every count has come back
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // result side back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d counts outstanding",
                     cycle_count, pending_count);
            $display("sieve_prime_count_test NOT OK");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_limits[k])
            send_limit(spc_pkg::FIELD_W'(directed_limits[k]));
        wait_for_drain();

        for (int k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k % PHASE_LEN == 0)
                gaps_on = ((k / PHASE_LEN) % 2) == 1;
            if ($urandom_range(0, 19) == 0)
                wait_for_drain();
            send_limit(pick_limit());
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d limits (%0d at or past the sieve size, %0d below three)",
                 sent_count, saturated_count, tiny_count);
        $display("checked %0d prime counts in %0d cycles", checked_count, cycle_count);
        if (fail_count == 0 && pending_count == 0)
            $display("sieve_prime_count_test OK");
        else
            $display("sieve_prime_count_test NOT OK");
        $finish;
    end

endmodule
